// ===== hw/rtl/mtnsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtnsp_pkg
// Shared widths, command and result codes, and the control bundles used
// by the neighborhood slot probe and its units.
// ----------------------------------------------------------------------------
package mtnsp_pkg;

  localparam int TABLES_DEF     = 8;
  localparam int SLOTS_DEF      = 1024;
  localparam int MAX_OFFSET_DEF = 3;
  localparam int COUNT_BITS_DEF = 16;

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int SEL_W   = 3;
  localparam int SLOT_W  = 10;
  localparam int HASH_W  = 32;
  localparam int ACNT_W  = 16;
  localparam int KIND_W  = 2;
  localparam int FCNT_W  = 6;

  // Configuration register widths
  localparam int TCNT_W     = 4;
  localparam int TSIZE_W    = 11;
  localparam int NOFF_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Internal widths: signed probe distance, signed position, list length
  localparam int DIST_W = 4;
  localparam int POS_W  = 13;
  localparam int LCNT_W = 8;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEIGH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_USED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGH_OFF   = 2'd2;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/mtnsp_divider.sv =====
// ----------------------------------------------------------------------------
// mtnsp_divider
// Restoring remainder unit: one dividend bit per cycle, remainder valid
// with the done pulse that ends the run.
// ----------------------------------------------------------------------------
module mtnsp_divider import mtnsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [HASH_W-1:0]  dividend_i,
  input  logic [TSIZE_W-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic [TSIZE_W-1:0] rem_o
);

  localparam int CW = $clog2(HASH_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(HASH_W - 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [HASH_W-1:0] dvd_q;
  logic [TSIZE_W-1:0] dvs_q, rem_q;
  logic [TSIZE_W:0]  trial;
  logic              ge;
  logic [TSIZE_W-1:0] rem_n;

  assign trial = {rem_q, dvd_q[HASH_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_n = ge ? TSIZE_W'(trial - {1'b0, dvs_q}) : TSIZE_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
      rem_q <= rem_n;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

// ===== hw/rtl/mtnsp_slot_mem.sv =====
// ----------------------------------------------------------------------------
// mtnsp_slot_mem
// Slot store: used bit and access count per slot. Sweeps every entry to zero
// after reset, then takes one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mtnsp_slot_mem import mtnsp_pkg::*; #(
  parameter int DEPTH      = TABLES_DEF * SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mem_ctrl_t             ctrl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic                  wused_i,
  input  logic [COUNT_BITS-1:0] wcnt_i,
  input  logic [AW-1:0]         raddr_i,
  output logic                  rused_o,
  output logic [COUNT_BITS-1:0] rcnt_o,
  output logic                  busy_o
);

  logic [COUNT_BITS:0] mem [DEPTH];
  logic [COUNT_BITS:0] rd_q;
  logic [AW-1:0]       clr_q;
  logic                busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (ctrl_i.we) begin
      mem[waddr_i] <= {wused_i, wcnt_i};
    end
    if (ctrl_i.re) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rused_o = rd_q[COUNT_BITS];
  assign rcnt_o  = rd_q[COUNT_BITS-1:0];
  assign busy_o  = busy_q;

endmodule

// ===== hw/rtl/multi_table_neighborhood_slot_probe.sv =====
// ----------------------------------------------------------------------------
// multi_table_neighborhood_slot_probe
// Cuckoo-style slot probe over several hash tables with neighbor slots:
// slot writes, hash loads, and find / neighbor queries answered as lists.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  in       | in_valid_i / in_stall_o   | cmd, table_sel, slot_index, hash,..
//  out      | out_valid_o / out_stall_i | kind, table, slot, count, list info
//  cfg      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  A hash load runs in the bit-serial remainder unit. A query then
//  re-reduces each home slot (through the remainder unit when it is not
//  below the table size) and walks the slot memory, a scan and an evaluate
//  state per slot, in counting passes each followed by an emit or count pass.
//  After reset the slot memory sweeps all TABLES * SLOTS entries (8192 by
//  default) while in_stall_o stays high. A stalled output holds the walk.
// ----------------------------------------------------------------------------
module multi_table_neighborhood_slot_probe import mtnsp_pkg::*; #(
  parameter int TABLES     = TABLES_DEF,
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_OFFSET = MAX_OFFSET_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [SEL_W-1:0]      table_sel_i,
  input  logic [SLOT_W-1:0]     slot_index_i,
  input  logic [HASH_W-1:0]     hash_value_i,
  input  logic                  slot_used_i,
  input  logic [ACNT_W-1:0]     slot_access_count_i,
  input  logic                  last_hash_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [SEL_W-1:0]      out_table_o,
  output logic [SLOT_W-1:0]     out_slot_o,
  output logic [ACNT_W-1:0]     out_access_count_o,
  output logic [FCNT_W-1:0]     found_count_o,
  output logic                  last_result_o
);

  localparam int DEPTH = TABLES * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TIW   = (TABLES > 1) ? $clog2(TABLES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RED, S_REDW, S_SCAN, S_EVAL, S_EMPTY
  } state_e;

  typedef enum logic [2:0] {
    P_HOME_CNT, P_HOME_EMIT, P_NB_CNT, P_NB_FREE,
    P_KICK_HOME, P_KICK_NB, P_ALL_CNT, P_ALL_EMIT
  } phase_e;

  // Configuration
  logic [TCNT_W-1:0]  tcount_q;
  logic [TSIZE_W-1:0] tsize_q;
  logic [NOFF_W-1:0]  noff_q;
  logic [TCNT_W-1:0]  eff_n;
  logic [TSIZE_W-1:0] eff_sz;
  logic [DIST_W-1:0]  eff_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= TCNT_W'(8);
      tsize_q  <= TSIZE_W'(1024);
      noff_q   <= NOFF_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TABLE_COUNT: tcount_q <= cfg_data_i[TCNT_W-1:0];
        CFG_TABLE_SIZE:  tsize_q  <= cfg_data_i[TSIZE_W-1:0];
        CFG_NEIGH_OFF:   noff_q   <= cfg_data_i[NOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tcount_q == '0)          eff_n = TCNT_W'(1);
    else if (tcount_q > TABLES)  eff_n = TCNT_W'(TABLES);
    else                         eff_n = tcount_q;
    if (tsize_q == '0)           eff_sz = TSIZE_W'(1);
    else if (tsize_q > SLOTS)    eff_sz = TSIZE_W'(SLOTS);
    else                         eff_sz = tsize_q;
    if (noff_q > MAX_OFFSET)     eff_off = DIST_W'(MAX_OFFSET);
    else                         eff_off = DIST_W'(noff_q);
  end

  // Control state
  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [TCNT_W-1:0]  t_q, t_d;
  logic signed [DIST_W-1:0] d_q, d_d;
  logic [TSIZE_W-1:0] p_q, p_d;
  logic [LCNT_W-1:0]  nfree_q, nfree_d, nused_q, nused_d;
  logic [LCNT_W-1:0]  total_q, total_d, emit_q, emit_d;
  logic               out_valid_q, out_valid_d;
  logic [TIW-1:0]     sel_q, sel_d;
  logic               last_q, last_d;
  logic               isfind_q, isfind_d;

  logic [TSIZE_W-1:0] home_q [TABLES];
  logic [TSIZE_W-1:0] hred_q [TABLES];

  // Units
  mem_ctrl_t          mem_ctrl;
  logic [AW-1:0]      waddr, raddr;
  logic               rused, mem_busy;
  logic [COUNT_BITS-1:0] rcnt;
  logic               div_start;
  logic [HASH_W-1:0]  div_dvd;
  div_stat_t          div_stat;
  logic [TSIZE_W-1:0] div_rem;

  mtnsp_slot_mem #(.DEPTH(DEPTH), .COUNT_BITS(COUNT_BITS)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .waddr_i (waddr),
    .wused_i (slot_used_i),
    .wcnt_i  (COUNT_BITS'(slot_access_count_i)),
    .raddr_i (raddr),
    .rused_o (rused),
    .rcnt_o  (rcnt),
    .busy_o  (mem_busy)
  );

  mtnsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (eff_sz),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // Probe position
  logic [TSIZE_W-1:0]       hsel, hraw;
  logic signed [POS_W-1:0]  pos;
  logic signed [DIST_W-1:0] off_s, noff_s;
  logic t_up, d_fixed, d_up, skip0, is_emit, match;
  logic last_d_step, last_t_step, pos_end, pos_ok;
  logic [TCNT_W-1:0]        nt;
  logic signed [DIST_W-1:0] nd;
  logic [KIND_W-1:0]        emit_kind;

  assign hsel   = hred_q[TIW'(t_q)];
  assign hraw   = home_q[TIW'(t_q)];
  assign off_s  = eff_off;
  assign noff_s = -eff_off;
  assign pos    = $signed({2'b00, hsel}) + POS_W'(d_q);

  always_comb begin
    t_up    = (phase_q == P_HOME_CNT) || (phase_q == P_HOME_EMIT) ||
              (phase_q == P_NB_FREE) || (phase_q == P_ALL_CNT) ||
              (phase_q == P_ALL_EMIT);
    d_fixed = (phase_q == P_HOME_CNT) || (phase_q == P_HOME_EMIT) ||
              (phase_q == P_KICK_HOME);
    d_up    = (phase_q == P_NB_FREE);
    skip0   = (phase_q == P_NB_CNT) || (phase_q == P_NB_FREE) ||
              (phase_q == P_KICK_NB);
    is_emit = (phase_q == P_HOME_EMIT) || (phase_q == P_NB_FREE) ||
              (phase_q == P_KICK_HOME) || (phase_q == P_KICK_NB) ||
              (phase_q == P_ALL_EMIT);
    case (phase_q)
      P_HOME_CNT, P_HOME_EMIT, P_NB_FREE: match = !rused;
      P_KICK_HOME:                        match = 1'b1;
      default:                            match = rused;
    endcase
    case (phase_q)
      P_KICK_HOME, P_KICK_NB: emit_kind = KIND_KICK;
      P_ALL_EMIT:             emit_kind = KIND_USED;
      default:                emit_kind = KIND_FREE;
    endcase
    pos_ok = !pos[POS_W-1] && (pos < $signed({2'b00, eff_sz})) &&
             !(skip0 && (d_q == '0));
    if (d_fixed)   last_d_step = 1'b1;
    else if (d_up) last_d_step = (d_q == off_s);
    else           last_d_step = (d_q == noff_s);
    last_t_step = t_up ? (t_q == eff_n - TCNT_W'(1)) : (t_q == '0);
    pos_end     = last_d_step && last_t_step;
    nt = t_up ? t_q + TCNT_W'(1) : t_q - TCNT_W'(1);
    nd = d_up ? d_q + DIST_W'(1) : d_q - DIST_W'(1);
  end

  function automatic logic [TCNT_W-1:0] ph_t0(phase_e ph, logic [TCNT_W-1:0] n);
    case (ph)
      P_NB_CNT, P_KICK_HOME, P_KICK_NB: ph_t0 = n - TCNT_W'(1);
      default:                          ph_t0 = '0;
    endcase
  endfunction

  function automatic logic signed [DIST_W-1:0] ph_d0(phase_e ph,
      logic signed [DIST_W-1:0] o);
    case (ph)
      P_HOME_CNT, P_HOME_EMIT, P_KICK_HOME: ph_d0 = '0;
      P_NB_FREE:                            ph_d0 = -o;
      default:                              ph_d0 = o;
    endcase
  endfunction

  // Output register
  logic               out_free, out_load;
  logic [KIND_W-1:0]  ld_kind;
  logic               ld_none;
  logic               home_we, hred_we;
  logic [TSIZE_W-1:0] hred_val;
  logic               do_adv, in_accept;
  phase_e             nph;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = mem_busy || (state_q != S_IDLE);

  assign waddr = AW'(32'(table_sel_i) * SLOTS + 32'(slot_index_i));
  assign raddr = AW'(32'(t_q) * SLOTS + 32'(pos[TSIZE_W-1:0]));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    t_d         = t_q;
    d_d         = d_q;
    p_d         = p_q;
    nfree_d     = nfree_q;
    nused_d     = nused_q;
    total_d     = total_q;
    emit_d      = emit_q;
    sel_d       = sel_q;
    last_d      = last_q;
    isfind_d    = isfind_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    ld_kind     = emit_kind;
    ld_none     = 1'b0;
    mem_ctrl    = '0;
    div_start   = 1'b0;
    div_dvd     = hash_value_i;
    home_we     = 1'b0;
    hred_we     = 1'b0;
    hred_val    = hraw;
    do_adv      = 1'b0;
    nph         = phase_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          sel_d    = TIW'(table_sel_i);
          last_d   = last_hash_i;
          isfind_d = (cmd_i == CMD_FIND);
          case (cmd_i)
            CMD_WRITE: begin
              mem_ctrl.we = (table_sel_i < TABLES) && (slot_index_i < SLOTS);
            end
            CMD_FIND, CMD_NEIGH: begin
              if (table_sel_i < TABLES) begin
                div_start = 1'b1;
                state_d   = S_LOAD;
              end else if (last_hash_i) begin
                t_d     = '0;
                state_d = S_RED;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        if (div_stat.done) begin
          home_we = 1'b1;
          t_d     = '0;
          state_d = last_q ? S_RED : S_IDLE;
        end
      end
      S_RED: begin
        // Re-reduce a home slot only when it is not below the current table size
        if (hraw < eff_sz) begin
          hred_we = 1'b1;
        end else begin
          div_dvd   = HASH_W'(hraw);
          div_start = 1'b1;
          state_d   = S_REDW;
        end
      end
      S_REDW: begin
        if (div_stat.done) begin
          hred_we  = 1'b1;
          hred_val = div_rem;
        end
      end
      S_SCAN: begin
        if (pos_ok) begin
          mem_ctrl.re = 1'b1;
          p_d         = pos[TSIZE_W-1:0];
          state_d     = S_EVAL;
        end else begin
          do_adv = 1'b1;
        end
      end
      S_EVAL: begin
        if (is_emit) begin
          if (!match) begin
            do_adv = 1'b1;
          end else if (out_free) begin
            out_load = 1'b1;
            emit_d   = emit_q + LCNT_W'(1);
            do_adv   = 1'b1;
          end
        end else begin
          do_adv = 1'b1;
          if (rused) nused_d = nused_q + LCNT_W'(1);
          else       nfree_d = nfree_q + LCNT_W'(1);
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_none  = 1'b1;
          ld_kind  = KIND_NONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Finish a home-slot reduction; after the last table start the first counting pass
    if (hred_we) begin
      if (t_q == eff_n - TCNT_W'(1)) begin
        nph     = isfind_q ? P_HOME_CNT : P_ALL_CNT;
        phase_d = nph;
        t_d     = ph_t0(nph, eff_n);
        d_d     = ph_d0(nph, off_s);
        nfree_d = '0;
        nused_d = '0;
        state_d = S_SCAN;
      end else begin
        t_d     = t_q + TCNT_W'(1);
        state_d = S_RED;
      end
    end

    if (do_adv) begin
      state_d = S_SCAN;
      if (!pos_end) begin
        if (last_d_step) begin
          t_d = nt;
          d_d = ph_d0(phase_q, off_s);
        end else begin
          d_d = nd;
        end
      end else begin
        case (phase_q)
          P_HOME_CNT: begin
            if (nfree_d != '0) begin
              nph = P_HOME_EMIT;
              total_d = nfree_d;
              emit_d  = '0;
            end else begin
              nph = P_NB_CNT;
            end
          end
          P_NB_CNT: begin
            emit_d = '0;
            if (nfree_d != '0) begin
              nph = P_NB_FREE;
              total_d = nfree_d;
            end else begin
              // The home pass already counted every (occupied) home slot
              nph = P_KICK_HOME;
              total_d = nused_d;
            end
          end
          P_KICK_HOME: nph = P_KICK_NB;
          P_ALL_CNT: begin
            emit_d = '0;
            if (nused_d != '0) begin
              nph = P_ALL_EMIT;
              total_d = nused_d;
            end else begin
              state_d = S_EMPTY;
            end
          end
          default: state_d = S_IDLE;
        endcase
        phase_d = nph;
        t_d     = ph_t0(nph, eff_n);
        d_d     = ph_d0(nph, off_s);
      end
    end

    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_HOME_CNT;
      t_q         <= '0;
      d_q         <= '0;
      p_q         <= '0;
      nfree_q     <= '0;
      nused_q     <= '0;
      total_q     <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= '0;
      last_q      <= 1'b0;
      isfind_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      t_q         <= t_d;
      d_q         <= d_d;
      p_q         <= p_d;
      nfree_q     <= nfree_d;
      nused_q     <= nused_d;
      total_q     <= total_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      last_q      <= last_d;
      isfind_q    <= isfind_d;
    end
  end

  // Home slots and their reduced copies
  always_ff @(posedge clk_i) begin
    if (home_we) home_q[sel_q] <= div_rem;
    if (hred_we) hred_q[TIW'(t_q)] <= hred_val;
  end

  // Result payload
  logic [KIND_W-1:0] kind_q;
  logic [SEL_W-1:0]  otab_q;
  logic [SLOT_W-1:0] oslot_q;
  logic [ACNT_W-1:0] ocnt_q;
  logic [FCNT_W-1:0] fcnt_q;
  logic              olast_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= ld_kind;
      otab_q  <= ld_none ? '0 : SEL_W'(t_q);
      oslot_q <= ld_none ? '0 : SLOT_W'(p_q);
      ocnt_q  <= ld_none ? '0 : ACNT_W'(rcnt);
      fcnt_q  <= ld_none ? '0 : FCNT_W'(total_q);
      olast_q <= ld_none || ((emit_q + LCNT_W'(1)) == total_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign out_table_o        = otab_q;
  assign out_slot_o         = oslot_q;
  assign out_access_count_o = ocnt_q;
  assign found_count_o      = fcnt_q;
  assign last_result_o      = olast_q;

  // Checks
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= total_q) else $error("emitted more results than counted");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_LOAD || state_q == S_REDW))
    else $error("remainder ready with no consumer");

  a_no_read_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.re |-> !mem_busy) else $error("slot read during clearing sweep");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(kind_q) && $stable(oslot_q))
    else $error("pending result overwritten");

endmodule
